/* rtl/bis_pkg.sv */
// Shared package of the bit-vector index set: sizes, action and state codes,
// controller/datapath command and status structs, and word helper functions.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

  localparam int MAX_INDICES = 1024;
  localparam int WORD_BITS   = 8;
  localparam int NUM_WORDS   = (MAX_INDICES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = $clog2(NUM_WORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WCNT_W      = $clog2(WORD_BITS + 1);

  // Field widths fixed by the interface
  localparam int ACT_W  = 4;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 7;
  localparam int SIZE_W = 11;
  localparam int CNT_W  = 11;

  localparam logic [SIZE_W-1:0]  SIZE_MAX  = SIZE_W'(MAX_INDICES);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  // APB register map
  localparam int   APB_AW          = 3;
  localparam int   APB_DW          = 32;
  localparam logic REG_SIZE_IN_USE = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD       = 4'd0,
    ACT_REMOVE    = 4'd1,
    ACT_TEST      = 4'd2,
    ACT_NTH       = 4'd3,
    ACT_COUNT     = 4'd4,
    ACT_INVERT    = 4'd5,
    ACT_SET_ALL   = 4'd6,
    ACT_CLEAR_ALL = 4'd7,
    ACT_OR_WORD   = 4'd8,
    ACT_AND_WORD  = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_UPDATE,
    ST_SWEEP,
    ST_TRIM,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
    logic sweep_start;
    logic trim;
    logic clear_all;
    logic finish;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    range_err;
    logic    sweep_done;
  } sts_t;

  function automatic logic [WCNT_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [WCNT_W-1:0] c;
    c = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      c = c + WCNT_W'(w[b]);
    end
    return c;
  endfunction

  // Bits of word w that lie below size sz
  function automatic logic [WORD_BITS-1:0] valid_mask(input logic [WADDR_W-1:0] w,
                                                      input logic [SIZE_W-1:0]  sz);
    logic [SIZE_W:0]        lo;
    logic [WORD_BITS-1:0]   m;
    lo = (SIZE_W+1)'({w, BIT_W'(0)});
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = ((lo + (SIZE_W+1)'(b)) < {1'b0, sz});
    end
    return m;
  endfunction

  // Position of the set bit of rank r (from zero) in word w
  function automatic logic [BIT_W-1:0] select_bit(input logic [WORD_BITS-1:0] w,
                                                  input logic [BIT_W-1:0]     r);
    logic [WCNT_W-1:0] cnt;
    logic [BIT_W-1:0]  pos;
    logic              hit;
    cnt = '0;
    pos = '0;
    hit = 1'b0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (w[b] && !hit) begin
        if (cnt == {1'b0, r}) begin
          pos = BIT_W'(b);
          hit = 1'b1;
        end
        cnt = cnt + 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* rtl/bis_req_if.sv */
// Request channel of the index set: valid/ready handshake and request fields.
// Depends on bis_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bis_req_if;
  import bis_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [IDX_W-1:0]  index;
  logic [IDX_W-1:0]  nth;
  logic [POS_W-1:0]  word_position;
  logic [WORD_BITS-1:0] word_data;

  modport source (output valid, action, index, nth, word_position, word_data,
                  input ready);
  modport sink   (input valid, action, index, nth, word_position, word_data,
                  output ready);
endinterface

`default_nettype wire

/* rtl/bis_rsp_if.sv */
// Result channel of the index set: valid/ready handshake and result fields.
// Depends on bis_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bis_rsp_if;
  import bis_pkg::*;

  logic             valid;
  logic             ready;
  logic             in_set;
  logic [IDX_W-1:0] found_index;
  logic             found;
  logic [CNT_W-1:0] member_count;
  logic             range_error;

  modport source (output valid, in_set, found_index, found, member_count, range_error,
                  input ready);
  modport sink   (input valid, in_set, found_index, found, member_count, range_error,
                  output ready);
endinterface

`default_nettype wire

/* rtl/bis_datapath.sv */
// Datapath of the index set: word memory with valid bits, live count, sweep
// pipeline, request and result registers. Driven by bis_ctrl through bis_pkg structs.
`timescale 1ns / 1ps
`default_nettype none

module bis_datapath import bis_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [SIZE_W-1:0]    size_i,
  input  logic [ACT_W-1:0]     action_i,
  input  logic [IDX_W-1:0]     index_i,
  input  logic [IDX_W-1:0]     nth_i,
  input  logic [POS_W-1:0]     word_position_i,
  input  logic [WORD_BITS-1:0] word_data_i,
  output logic                 in_set_o,
  output logic [IDX_W-1:0]     found_index_o,
  output logic                 found_o,
  output logic [CNT_W-1:0]     member_count_o,
  output logic                 range_error_o
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;

  action_e              act_q;
  logic [IDX_W-1:0]     idx_q;
  logic [IDX_W-1:0]     nth_q;
  logic [POS_W-1:0]     pos_q;
  logic [WORD_BITS-1:0] data_q;

  logic                 range_err_q, in_set_q, found_q;
  logic [IDX_W-1:0]     found_idx_q;
  logic [CNT_W-1:0]     live_q, acc_q;
  logic [SIZE_W-1:0]    seen_q;

  logic                 swp_q, pipe_vld_q, trim_q;
  logic [WADDR_W-1:0]   rd_cnt_q, pipe_addr_q;

  action_e              act_in;
  logic                 range_in;
  logic [WADDR_W-1:0]   single_addr, rd_addr, wr_addr;
  logic [BIT_W-1:0]     bit_sel;
  logic [WORD_BITS-1:0] bit_mask, word, upd_word, swp_word, wr_data;
  logic [CNT_W-1:0]     upd_cnt, acc_sum;
  logic [WCNT_W-1:0]    word_pc;
  logic [SIZE_W:0]      seen_sum;
  logic [SIZE_W-1:0]    rank_full;
  logic                 rd_en, wr_en, swp_we, nth_hit, sweep_done;

  // Range check of the incoming request
  always_comb begin
    act_in   = action_e'(action_i);
    range_in = 1'b0;
    if (act_in inside {ACT_ADD, ACT_REMOVE, ACT_TEST}) begin
      range_in = ({1'b0, index_i} >= size_i);
    end else if (act_in inside {ACT_OR_WORD, ACT_AND_WORD}) begin
      range_in = (SIZE_W'({word_position_i, BIT_W'(0)}) >= size_i);
    end
  end

  assign single_addr = (act_q inside {ACT_OR_WORD, ACT_AND_WORD}) ? pos_q
                                                                  : idx_q[IDX_W-1:BIT_W];
  assign bit_sel     = idx_q[BIT_W-1:0];
  assign bit_mask    = WORD_BITS'(1) << bit_sel;
  assign word        = rd_vld_q ? rd_data_q : '0;
  assign word_pc     = popcount(word);

  assign rd_en   = cmd_i.lookup || swp_q;
  assign rd_addr = swp_q ? rd_cnt_q : single_addr;

  // Single-word update
  always_comb begin
    case (act_q)
      ACT_ADD:      upd_word = word | bit_mask;
      ACT_REMOVE:   upd_word = word & ~bit_mask;
      ACT_OR_WORD:  upd_word = (word | data_q) & valid_mask(pos_q, size_i);
      ACT_AND_WORD: upd_word = word & data_q;
      default:      upd_word = word;
    endcase
  end
  assign upd_cnt = live_q - CNT_W'(word_pc) + CNT_W'(popcount(upd_word));

  // Sweep processing of the word returned for pipe_addr_q
  always_comb begin
    if (trim_q) begin
      swp_word = word & valid_mask(pipe_addr_q, size_i);
    end else begin
      case (act_q)
        ACT_INVERT:  swp_word = ~word & valid_mask(pipe_addr_q, size_i);
        ACT_SET_ALL: swp_word = valid_mask(pipe_addr_q, size_i);
        default:     swp_word = word;
      endcase
    end
  end
  assign swp_we     = pipe_vld_q && (trim_q || (act_q inside {ACT_INVERT, ACT_SET_ALL}));
  assign acc_sum    = acc_q + CNT_W'(popcount(swp_word));
  assign sweep_done = pipe_vld_q && (pipe_addr_q == LAST_WORD);

  assign seen_sum  = {1'b0, seen_q} + (SIZE_W+1)'(word_pc);
  assign rank_full = SIZE_W'(nth_q) - seen_q;
  assign nth_hit   = pipe_vld_q && !trim_q && (act_q == ACT_NTH) && !found_q
                     && (seen_sum > (SIZE_W+1)'(nth_q));

  assign wr_en   = (cmd_i.update && (act_q != ACT_TEST)) || swp_we;
  assign wr_addr = cmd_i.update ? single_addr : pipe_addr_q;
  assign wr_data = cmd_i.update ? upd_word : swp_word;

  // Word memory, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= act_in;
      idx_q  <= index_i;
      nth_q  <= nth_i;
      pos_q  <= word_position_i;
      data_q <= word_data_i;
    end
    if (cmd_i.sweep_start) begin
      pipe_addr_q <= rd_cnt_q;
    end else begin
      pipe_addr_q <= rd_cnt_q;
    end
    if (cmd_i.finish) begin
      in_set_o       <= in_set_q;
      found_index_o  <= found_idx_q;
      found_o        <= found_q;
      member_count_o <= live_q;
      range_error_o  <= range_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      live_q      <= '0;
      acc_q       <= '0;
      seen_q      <= '0;
      swp_q       <= 1'b0;
      pipe_vld_q  <= 1'b0;
      trim_q      <= 1'b0;
      rd_cnt_q    <= '0;
      range_err_q <= 1'b0;
      in_set_q    <= 1'b0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
    end else begin
      pipe_vld_q <= swp_q;

      if (cmd_i.clear_all) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end

      if (cmd_i.load) begin
        range_err_q <= range_in;
        in_set_q    <= 1'b0;
        found_q     <= 1'b0;
        found_idx_q <= '0;
      end

      if (cmd_i.update && (act_q == ACT_TEST)) begin
        in_set_q <= word[bit_sel];
      end

      // Sweep issue counter
      if (cmd_i.sweep_start) begin
        swp_q    <= 1'b1;
        trim_q   <= cmd_i.trim;
        rd_cnt_q <= '0;
        acc_q    <= '0;
        seen_q   <= '0;
      end else if (swp_q) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
        if (rd_cnt_q == LAST_WORD) begin
          swp_q <= 1'b0;
        end
      end

      if (pipe_vld_q) begin
        acc_q <= acc_sum;
      end

      if (nth_hit) begin
        found_q     <= 1'b1;
        found_idx_q <= {pipe_addr_q, select_bit(word, rank_full[BIT_W-1:0])};
      end else if (pipe_vld_q && !found_q) begin
        seen_q <= seen_sum[SIZE_W-1:0];
      end

      // Live member count
      if (cmd_i.clear_all) begin
        live_q <= '0;
      end else if (cmd_i.update) begin
        live_q <= upd_cnt;
      end else if (sweep_done) begin
        if (trim_q) begin
          live_q <= acc_sum;
        end else if (act_q == ACT_INVERT) begin
          live_q <= size_i - live_q;
        end else if (act_q == ACT_SET_ALL) begin
          live_q <= size_i;
        end
      end
    end
  end

  assign sts_o.action     = act_q;
  assign sts_o.range_err  = range_err_q;
  assign sts_o.sweep_done = sweep_done;

endmodule

`default_nettype wire

/* rtl/bis_ctrl.sv */
// Controller of the index set: sequences each request and the trim pass
// through the datapath. Uses the state, command and status types of bis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bis_ctrl import bis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic cfg_wr_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   out_vld_q, out_vld_d;

  assign in_ready_o  = (state_q == ST_IDLE) && !pend_q;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    out_vld_d = out_vld_q && !out_ready_i;
    pend_d    = pend_q;

    case (state_q)
      ST_IDLE: begin
        if (pend_q) begin
          cmd_o.sweep_start = 1'b1;
          cmd_o.trim        = 1'b1;
          pend_d            = 1'b0;
          state_d           = ST_TRIM;
        end else if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.range_err) begin
          state_d = ST_FINISH;
        end else if (sts_i.action inside {ACT_ADD, ACT_REMOVE, ACT_TEST,
                                          ACT_OR_WORD, ACT_AND_WORD}) begin
          cmd_o.lookup = 1'b1;
          state_d      = ST_UPDATE;
        end else if (sts_i.action inside {ACT_NTH, ACT_INVERT, ACT_SET_ALL}) begin
          cmd_o.sweep_start = 1'b1;
          state_d           = ST_SWEEP;
        end else if (sts_i.action == ACT_CLEAR_ALL) begin
          cmd_o.clear_all = 1'b1;
          state_d         = ST_FINISH;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_TRIM: begin
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A size write schedules a trim pass; writes during a pass queue one more
    if (cfg_wr_i) begin
      pend_d = 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DISPATCH)
    else $error("accepted request not dispatched");

  a_cfg_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> pend_q)
    else $error("size write did not schedule a trim pass");

  a_sweep_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.sweep_done |-> (state_q == ST_SWEEP || state_q == ST_TRIM))
    else $error("sweep finished outside a sweep state");
`endif

endmodule

`default_nettype wire

/* rtl/bitset_index_set_core.sv */
// Top level of the bit-vector index set: APB size register, controller and datapath.
// Depends on bis_pkg, bis_req_if, bis_rsp_if, bis_ctrl and bis_datapath.
`timescale 1ns / 1ps
`default_nettype none

// A set of up to MAX_INDICES indices kept as a 128-word by 8-bit memory with a
// live member count; every request returns exactly one result transfer that
// carries the count after the request. Add, remove, test and the OR/AND word
// merges go through dispatch with the registered memory read, write-back and
// result load; count, clear-all, unused actions and out-of-range requests go
// from dispatch straight to the result load. Nth-member, invert and set-all
// stream all 128 words through the single read port one word per cycle, and
// invert and set-all write each back through the write port. The next request
// transfer can come in the cycle after the result loads. Writing size_in_use
// (APB address 0) schedules a trim pass, started once the controller is idle,
// that zeroes bits at and above the new size and recounts the members; no
// request is accepted while it is pending or running, while further APB writes
// are still taken (any number of them queue one more pass).
// Sizes above MAX_INDICES act as MAX_INDICES. The store clears at reset
// through per-word valid bits, and clear-all drops them all at once. A new
// request may be taken while the previous result still waits in the output
// register.
module bitset_index_set_core import bis_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bis_req_if.sink           req_i,
  bis_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] size_eff;
  logic              reg_hit;
  logic              cfg_wr;
  cmd_t              cmd;
  sts_t              sts;

  // APB: zero-wait, register index from the word address
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_SIZE_IN_USE);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? APB_DW'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_MAX;
    end else if (cfg_wr) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  // Clamp the size to the store depth
  assign size_eff = (size_q > SIZE_MAX) ? SIZE_MAX : size_q;

  bis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cfg_wr_i    (cfg_wr),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bis_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .size_i          (size_eff),
    .action_i        (req_i.action),
    .index_i         (req_i.index),
    .nth_i           (req_i.nth),
    .word_position_i (req_i.word_position),
    .word_data_i     (req_i.word_data),
    .in_set_o        (rsp_o.in_set),
    .found_index_o   (rsp_o.found_index),
    .found_o         (rsp_o.found),
    .member_count_o  (rsp_o.member_count),
    .range_error_o   (rsp_o.range_error)
  );

endmodule

`default_nettype wire
